### sv/bqa_pkg.sv
// Shared types, constants and a helper function of the billboard quad animator.
package bqa_pkg;

    // Instance store
    localparam int DEF_INSTANCES = 64;
    localparam int REQ_W         = 6;

    // Frame position is Q9.16
    localparam int FRAME_W = 8;
    localparam int FRAC_W  = 16;
    localparam int FPOS_W  = 25;
    localparam int WHOLE_W = FPOS_W - FRAC_W;

    // Shared multiplier: signed 17-bit by unsigned 26-bit operand
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = 43;

    // Increment = floor((64*fps + 7) / 15), done as a multiply by 2^26/15 rounded up.
    // The 23-bit reciprocal is split into a high and a low part so each pass fits the multiplier.
    localparam int INC_LO_W = 13;
    localparam int INC_SHIFT = 26;
    localparam int INC_W = 19;
    localparam int ACC_W = 33;
    localparam int INC_SUM_W = ACC_W + INC_LO_W;
    localparam logic signed [MUL_A_W-1:0] INC_MUL_HI = 17'sd546;
    localparam logic signed [MUL_A_W-1:0] INC_MUL_LO = 17'sd1093;
    localparam logic [5:0] INC_BIAS = 6'd7;

    // Product of base size and scale, and the half offset along the right vector
    localparam int BS_W   = 26;
    localparam int SIZE_W = 25;
    localparam int RND_W  = MUL_P_W + 1;
    localparam int OFS_SHIFT = 17;
    localparam int OFS_W  = RND_W - OFS_SHIFT;
    localparam logic signed [RND_W-1:0] OFS_HALF = 44'sd65536;

    // Coordinates
    localparam int COORD_W = 24;
    localparam int CALC_W  = 28;
    localparam logic signed [CALC_W-1:0] COORD_MAX = 28'sd8388607;
    localparam logic signed [CALC_W-1:0] COORD_MIN = -28'sd8388608;

    // Corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]          instance_req;
        logic signed [15:0]        right_x;
        logic signed [15:0]        right_z;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [9:0]                base_size;
        logic [15:0]               scale;
        logic [15:0]               fps;
        logic [FRAME_W-1:0]        first_frame;
        logic [FRAME_W-1:0]        last_frame;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic                      tex_u;
        logic                      tex_v;
        logic [FRAME_W-1:0]        frame_index;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic upd_en;
    } t_frame_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS,
        ST_INC_HI,
        ST_INC_LO,
        ST_DX,
        ST_DZ,
        ST_DZ_DONE,
        ST_OUT
    } t_state;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [CALC_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v > COORD_MAX) begin
            res = COORD_MAX[COORD_W-1:0];
        end else if (v < COORD_MIN) begin
            res = COORD_MIN[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/bqa_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module bqa_mul (
    input  logic                                 i_clk,
    input  logic signed [bqa_pkg::MUL_A_W-1:0]   i_a,
    input  logic [bqa_pkg::MUL_B_W-1:0]          i_b,
    output logic signed [bqa_pkg::MUL_P_W-1:0]   o_p
);
    import bqa_pkg::*;

    logic signed [MUL_P_W:0]   w_full;
    logic signed [MUL_P_W-1:0] r_p;

    assign w_full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_p <= w_full[MUL_P_W-1:0];
    end

    assign o_p = r_p;

endmodule

### sv/bqa_frame.sv
// Per-instance frame position store with the advance, wrap and clamp step.
module bqa_frame #(
    parameter int INSTANCES = bqa_pkg::DEF_INSTANCES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bqa_pkg::t_frame_ctl            i_ctl,
    input  logic [bqa_pkg::REQ_W-1:0]      i_req,
    input  logic [bqa_pkg::INC_W-1:0]      i_inc,
    input  logic [bqa_pkg::FRAME_W-1:0]    i_first,
    input  logic [bqa_pkg::FRAME_W-1:0]    i_last,
    output logic [bqa_pkg::FRAME_W-1:0]    o_frame_index
);
    import bqa_pkg::*;

    localparam int IDX_W = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int EXT_W = (IDX_W > REQ_W) ? IDX_W : REQ_W;
    localparam int CMP_W = EXT_W + 1;

    logic [FPOS_W-1:0]  r_mem [INSTANCES];
    logic [INSTANCES-1:0] r_started;
    logic [FPOS_W-1:0]  r_rd_pos;
    logic [IDX_W-1:0]   r_addr;
    logic               r_hit;
    logic               r_in_range;
    logic [FRAME_W-1:0] r_frame_index;

    logic [EXT_W-1:0]   w_req_ext;
    logic [IDX_W-1:0]   w_addr;
    logic               w_in_range;
    logic [FRAME_W-1:0] w_hi;
    logic [FPOS_W-1:0]  w_first_pos;
    logic [FPOS_W-1:0]  w_base;
    logic [FPOS_W:0]    w_sum;
    logic [FPOS_W:0]    w_limit;
    logic [FPOS_W-1:0]  w_pos;
    logic [WHOLE_W-1:0] w_whole;
    logic [FRAME_W-1:0] w_clamped;

    assign w_req_ext  = EXT_W'(i_req);
    assign w_addr     = w_req_ext[IDX_W-1:0];
    assign w_in_range = {1'b0, w_req_ext} < CMP_W'(INSTANCES);

    // An inverted range collapses onto the first frame.
    assign w_hi        = (i_last < i_first) ? i_first : i_last;
    assign w_first_pos = FPOS_W'({i_first, {FRAC_W{1'b0}}});
    assign w_base      = r_hit ? r_rd_pos : w_first_pos;
    assign w_sum       = {1'b0, w_base} + (FPOS_W + 1)'(i_inc);
    assign w_limit     = (FPOS_W + 1)'({WHOLE_W'(w_hi) + WHOLE_W'(1), {FRAC_W{1'b0}}});
    assign w_pos       = (w_sum >= w_limit) ? w_first_pos : w_sum[FPOS_W-1:0];
    assign w_whole     = w_pos[FPOS_W-1:FRAC_W];

    always_comb begin
        if (w_whole < WHOLE_W'(i_first)) begin
            w_clamped = i_first;
        end else if (w_whole > WHOLE_W'(w_hi)) begin
            w_clamped = w_hi;
        end else begin
            w_clamped = w_whole[FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_pos <= r_mem[w_addr];
            r_addr   <= w_addr;
        end
        if (i_ctl.upd_en && r_in_range) begin
            r_mem[r_addr] <= w_pos;
        end
        if (i_ctl.upd_en) begin
            r_frame_index <= w_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= '0;
            r_hit      <= 1'b0;
            r_in_range <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_in_range <= w_in_range;
                r_hit      <= w_in_range && r_started[w_addr];
            end
            if (i_ctl.upd_en && r_in_range) begin
                r_started[r_addr] <= 1'b1;
            end
        end
    end

    assign o_frame_index = r_frame_index;

endmodule

### sv/billboard_quad_animator.sv
// Top level: sequencer around the shared multiplier, frame store and corner output register.
//
// Usage: one input transaction carries one sprite instance for one video frame; the block
// answers with four output transactions, the quad corners top left, top right, bottom right
// and bottom left, the last one flagged by the last field.
// Both channels use valid/stall. o_in_stall is high from the cycle after an input
// transaction until the fourth corner has been loaded into the output register, so the block
// works on one instance at a time.
// Each instance takes five passes through the one shared multiplier (size product, two parts
// of the frame increment, offsets along x and z), one step that drains the last product,
// four steps that load one corner each, and one step in idle taking the next instance.
// Output stall: a corner waits in the output register and the sequencer holds until it is
// taken; the next instance can be accepted while the fourth corner still waits.
// Reset (synchronous, active low) clears the sequencer, the output valid and all started
// flags, so every instance begins again at its first frame. Frame positions need no clear.
module billboard_quad_animator #(
    parameter int INSTANCES = bqa_pkg::DEF_INSTANCES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bqa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bqa_pkg::t_out_item o_out_item
);
    import bqa_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    t_in_item                  r_item;
    logic [BS_W-1:0]           r_bs;
    logic [ACC_W-1:0]          r_acc;
    logic [INC_W-1:0]          r_inc;
    logic signed [OFS_W-1:0]   r_dx;
    logic signed [OFS_W-1:0]   r_dz;
    logic [1:0]                r_corner;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0]        w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    t_frame_ctl                w_frame_ctl;
    logic                      w_load;
    logic [FRAME_W-1:0]        w_frame_index;

    logic [INC_SUM_W-1:0]      w_inc_sum;
    logic signed [RND_W-1:0]   w_prod_rnd;
    logic [BS_W:0]             w_bs_rnd;
    logic [SIZE_W-1:0]         w_size;
    logic                      w_right;
    logic                      w_bottom;
    logic signed [CALC_W-1:0]  w_px;
    logic signed [CALC_W-1:0]  w_py;
    logic signed [CALC_W-1:0]  w_pz;
    logic signed [CALC_W-1:0]  w_vx;
    logic signed [CALC_W-1:0]  w_vy;
    logic signed [CALC_W-1:0]  w_vz;
    t_out_item                 w_corner_item;

    bqa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    bqa_frame #(
        .INSTANCES (INSTANCES)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_frame_ctl),
        .i_req         (i_in_item.instance_req),
        .i_inc         (r_inc),
        .i_first       (r_item.first_frame),
        .i_last        (r_item.last_frame),
        .o_frame_index (w_frame_index)
    );

    // Sequencer: the five multiply states feed the shared multiplier; the others do not.
    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_frame_ctl = '0;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_frame_ctl.rd_en = 1'b1;
                    n_state           = ST_BS;
                end
            end
            ST_BS: begin
                w_mul_a = MUL_A_W'(r_item.base_size);
                w_mul_b = MUL_B_W'(r_item.scale);
                n_state = ST_INC_HI;
            end
            ST_INC_HI: begin
                w_mul_a = INC_MUL_HI;
                w_mul_b = MUL_B_W'({r_item.fps, INC_BIAS});
                n_state = ST_INC_LO;
            end
            ST_INC_LO: begin
                w_mul_a = INC_MUL_LO;
                w_mul_b = MUL_B_W'({r_item.fps, INC_BIAS});
                n_state = ST_DX;
            end
            ST_DX: begin
                w_mul_a = MUL_A_W'(r_item.right_x);
                w_mul_b = r_bs;
                n_state = ST_DZ;
            end
            ST_DZ: begin
                w_mul_a            = MUL_A_W'(r_item.right_z);
                w_mul_b            = r_bs;
                w_frame_ctl.upd_en = 1'b1;
                n_state            = ST_DZ_DONE;
            end
            ST_DZ_DONE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load = 1'b1;
                    if (r_corner == CORNER_BL) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The two reciprocal parts are recombined here; the sum shifted down is the increment.
    assign w_inc_sum  = {r_acc, {INC_LO_W{1'b0}}} + INC_SUM_W'(w_prod[ACC_W-1:0]);
    // Half offset rounds with ties toward plus infinity.
    assign w_prod_rnd = RND_W'(w_prod) + OFS_HALF;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_item <= i_in_item;
        end
        if (r_state == ST_INC_HI) begin
            r_bs <= w_prod[BS_W-1:0];
        end
        if (r_state == ST_INC_LO) begin
            r_acc <= w_prod[ACC_W-1:0];
        end
        if (r_state == ST_DX) begin
            r_inc <= w_inc_sum[INC_SHIFT+INC_W-1:INC_SHIFT];
        end
        if (r_state == ST_DZ) begin
            r_dx <= w_prod_rnd[RND_W-1:OFS_SHIFT];
        end
        if (r_state == ST_DZ_DONE) begin
            r_dz <= w_prod_rnd[RND_W-1:OFS_SHIFT];
        end
        if (w_load) begin
            r_out <= w_corner_item;
        end
    end

    // Corner assembly
    assign w_bs_rnd = (BS_W + 1)'(r_bs) + (BS_W + 1)'(2);
    assign w_size   = w_bs_rnd[BS_W:2];
    assign w_right  = (r_corner == CORNER_TR) || (r_corner == CORNER_BR);
    assign w_bottom = (r_corner == CORNER_BR) || (r_corner == CORNER_BL);
    assign w_px     = CALC_W'(r_item.pos_x);
    assign w_py     = CALC_W'(r_item.pos_y);
    assign w_pz     = CALC_W'(r_item.pos_z);
    assign w_vx     = w_right ? (w_px + CALC_W'(r_dx)) : (w_px - CALC_W'(r_dx));
    assign w_vz     = w_right ? (w_pz + CALC_W'(r_dz)) : (w_pz - CALC_W'(r_dz));
    assign w_vy     = w_bottom ? w_py : (w_py + $signed(CALC_W'(w_size)));

    always_comb begin
        w_corner_item.corner      = r_corner;
        w_corner_item.vert_x      = sat_coord(w_vx);
        w_corner_item.vert_y      = sat_coord(w_vy);
        w_corner_item.vert_z      = sat_coord(w_vz);
        w_corner_item.tex_u       = w_right;
        w_corner_item.tex_v       = w_bottom;
        w_corner_item.frame_index = w_frame_index;
        w_corner_item.last        = (r_corner == CORNER_BL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_corner    <= CORNER_TL;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_corner    <= r_corner + 2'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/bqa_checker.sv
// Port-level checker for the billboard quad animator and its bind.
module bqa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bqa_pkg::t_out_item o_out_item
);
    import bqa_pkg::*;

    // A stalled corner stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output transaction changed");

    // Once a corner other than the last is taken, the next corner follows at once.
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_out_item.corner != CORNER_BL)
        |=> o_out_valid && (o_out_item.corner == $past(o_out_item.corner) + 2'd1))
        else $error("quad corners out of sequence");

    // Flags must agree with the corner code.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last == (o_out_item.corner == CORNER_BL))
        && (o_out_item.tex_v == ((o_out_item.corner == CORNER_BR)
            || (o_out_item.corner == CORNER_BL)))
        && (o_out_item.tex_u == ((o_out_item.corner == CORNER_TR)
            || (o_out_item.corner == CORNER_BR))))
        else $error("corner flags disagree with corner code");

    // No new instance is taken while a quad is still being emitted.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.corner != CORNER_BL) |-> o_in_stall)
        else $error("input accepted in the middle of a quad");

endmodule

bind billboard_quad_animator bqa_checker u_bqa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

### test/billboard_quad_animator_test.sv
// Self-checking testbench for the billboard quad animator: frame animation and quad corners.
module billboard_quad_animator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bqa_pkg::*;

    localparam int NUM_INST     = DEF_INSTANCES;
    localparam int POOL_SIZE    = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 8;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int HALF_SHIFT   = 17;
    localparam longint HALF_ROUND = 65536;
    localparam longint ONE_FRAME_FPS = 15360;

    localparam logic [1:0] CORNER_ORDER [4] = '{CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BL};

    logic      clk;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Predicted animation state, one entry per sprite instance.
    logic [FPOS_W-1:0] frame_pos [NUM_INST];
    logic              anim_started [NUM_INST];

    // Frame ranges kept per pooled instance so that animations run long enough to wrap.
    logic [FRAME_W-1:0] pool_first [POOL_SIZE];
    logic [FRAME_W-1:0] pool_last [POOL_SIZE];

    t_in_item  pending_sprites [$];
    t_out_item expected_corners [$];

    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     sprites_accepted = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     errors = 0;
    longint cycle_count = 0;

    billboard_quad_animator #(
        .INSTANCES(NUM_INST)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
        longint c;
        c = v;
        if (c > 64'sd8388607) c = 64'sd8388607;
        if (c < -64'sd8388608) c = -64'sd8388608;
        return c[COORD_W-1:0];
    endfunction

    // Advances the instance's animation and queues the four corners it should produce.
    function automatic void predict_quad(input t_in_item s);
        logic [FRAME_W-1:0] lo;
        logic [FRAME_W-1:0] hi;
        longint pos;
        longint inc;
        longint whole;
        longint bs;
        longint size;
        longint dx;
        longint dz;
        longint px;
        longint py;
        longint pz;
        bit right;
        bit bottom;
        t_out_item c;
        lo = s.first_frame;
        hi = (s.last_frame < lo) ? lo : s.last_frame;
        if (anim_started[s.instance_req]) pos = longint'(frame_pos[s.instance_req]);
        else pos = longint'(lo) << FRAC_W;
        inc = (longint'(s.fps) * 256 + 30) / 60;
        pos = pos + inc;
        if (pos >= ((longint'(hi) + 1) << FRAC_W)) pos = longint'(lo) << FRAC_W;
        frame_pos[s.instance_req] = pos[FPOS_W-1:0];
        anim_started[s.instance_req] = 1'b1;

        whole = pos >>> FRAC_W;
        if (whole < longint'(lo)) whole = longint'(lo);
        if (whole > longint'(hi)) whole = longint'(hi);

        bs = longint'(s.base_size) * longint'(s.scale);
        size = (bs + 2) >>> 2;
        // Arithmetic shift is a floor, so adding half first rounds ties upward.
        dx = (longint'($signed(s.right_x)) * bs + HALF_ROUND) >>> HALF_SHIFT;
        dz = (longint'($signed(s.right_z)) * bs + HALF_ROUND) >>> HALF_SHIFT;
        px = longint'($signed(s.pos_x));
        py = longint'($signed(s.pos_y));
        pz = longint'($signed(s.pos_z));

        for (int k = 0; k < 4; k++) begin
            c.corner = CORNER_ORDER[k];
            right = (c.corner == CORNER_TR) || (c.corner == CORNER_BR);
            bottom = (c.corner == CORNER_BR) || (c.corner == CORNER_BL);
            c.vert_x = clamp_coord(right ? px + dx : px - dx);
            c.vert_y = clamp_coord(bottom ? py : py + size);
            c.vert_z = clamp_coord(right ? pz + dz : pz - dz);
            c.tex_u = right;
            c.tex_v = bottom;
            c.frame_index = whole[FRAME_W-1:0];
            c.last = (c.corner == CORNER_BL);
            expected_corners.push_back(c);
        end
    endfunction

    function automatic string describe_corner(input t_out_item c);
        return $sformatf("corner=%0d x=%0d y=%0d z=%0d u=%0b v=%0b frame=%0d last=%0b",
                         c.corner, c.vert_x, c.vert_y, c.vert_z, c.tex_u, c.tex_v,
                         c.frame_index, c.last);
    endfunction

    task automatic report_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_corner(input t_out_item got);
        t_out_item want;
        if (expected_corners.size() == 0) begin
            report_failure({"unexpected ", describe_corner(got)});
        end else begin
            want = expected_corners.pop_front();
            if (got.corner !== want.corner || got.vert_x !== want.vert_x ||
                got.vert_y !== want.vert_y || got.vert_z !== want.vert_z ||
                got.tex_u !== want.tex_u || got.tex_v !== want.tex_v ||
                got.frame_index !== want.frame_index || got.last !== want.last) begin
                report_failure({"expected ", describe_corner(want),
                                " actual ", describe_corner(got)});
            end
        end
    endtask

    function automatic t_in_item make_sprite(input int inst, input int rx, input int rz,
                                             input int px, input int py, input int pz,
                                             input int base, input int scl, input int fps,
                                             input int first, input int last_f);
        t_in_item s;
        s.instance_req = inst[REQ_W-1:0];
        s.right_x = rx[15:0];
        s.right_z = rz[15:0];
        s.pos_x = px[COORD_W-1:0];
        s.pos_y = py[COORD_W-1:0];
        s.pos_z = pz[COORD_W-1:0];
        s.base_size = base[9:0];
        s.scale = scl[15:0];
        s.fps = fps[15:0];
        s.first_frame = first[FRAME_W-1:0];
        s.last_frame = last_f[FRAME_W-1:0];
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] near_coord();
        int v;
        v = int'($urandom_range(0, 131071)) - 65536;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [15:0] pick_right();
        int v;
        if ($urandom_range(0, 9) < 7) begin
            v = int'($urandom_range(0, 32768)) - 16384;
            return v[15:0];
        end
        return 16'($urandom());
    endfunction

    function automatic void roll_pool_range(input int p);
        pool_first[p] = FRAME_W'($urandom_range(0, 250));
        pool_last[p] = pool_first[p] + FRAME_W'($urandom_range(0, 5));
        // Now and then an inverted range.
        if ($urandom_range(0, 9) == 0) pool_last[p] = pool_first[p] - 1;
    endfunction

    task automatic load_directed();
        // Largest quad with an axis-aligned right vector: the top edge saturates.
        pending_sprites.push_back(make_sprite(0, 16384, 0, 0, 0, 0, 1023, 65535, 0, 0, 0));
        // Coordinate extremes, diagonal right vector, fastest rate on a one-frame range.
        pending_sprites.push_back(make_sprite(1, -16384, -16384, 8388607, 8388607, -8388608,
                                              1023, 65535, 65535, 255, 255));
        // Right vector outside the unit circle, zero size, inverted frame range.
        pending_sprites.push_back(make_sprite(2, -32768, 32767, -8388608, -8388608, 8388607,
                                              0, 0, 65535, 10, 3));
        // Full frame range at the fastest rate, visited repeatedly.
        repeat (3) pending_sprites.push_back(make_sprite(3, 0, 16384, 100, -100, 256,
                                                         40, 256, 65535, 0, 255));
        // One frame per visit on a two-frame range: the second visit wraps.
        repeat (3) pending_sprites.push_back(make_sprite(4, 11585, -11585, 0, 0, 0,
                                                         3, 300, ONE_FRAME_FPS, 5, 6));
        // Range moved above the stored position: the index clamps to the first frame.
        pending_sprites.push_back(make_sprite(4, 11585, -11585, 0, 0, 0, 3, 300, 0, 100, 110));
        // Range moved below the stored position: the position wraps to the new first frame.
        pending_sprites.push_back(make_sprite(4, 11585, -11585, 0, 0, 0, 3, 300, 0, 0, 2));
        // Offset ties: plus one half rounds up, minus one half rounds toward zero.
        pending_sprites.push_back(make_sprite(5, 1, -1, 0, 0, 0, 256, 256, 1, 0, 7));
        // Size tie rounds up.
        pending_sprites.push_back(make_sprite(6, 1, 1, -1, 5, 1, 2, 1, 30, 0, 7));
        // Highest instance with all-ones patterns, seen twice.
        repeat (2) pending_sprites.push_back(make_sprite(63, 32767, -1, -1, -1, -1,
                                                         1023, 65535, 65535, 255, 0));
    endtask

    task automatic load_random(input int count);
        t_in_item s;
        int p;
        int sel;
        for (int p0 = 0; p0 < POOL_SIZE; p0++) roll_pool_range(p0);
        for (int n = 0; n < count; n++) begin
            // Most traffic revisits a few instances so that animations advance and wrap.
            if ($urandom_range(0, 99) < 75) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 99) < 8) roll_pool_range(p);
                s.instance_req = REQ_W'(p);
                s.first_frame = pool_first[p];
                s.last_frame = pool_last[p];
            end else begin
                s.instance_req = REQ_W'($urandom_range(0, NUM_INST - 1));
                s.first_frame = FRAME_W'($urandom());
                s.last_frame = FRAME_W'($urandom());
            end
            sel = $urandom_range(0, 9);
            if (sel < 5) s.fps = 16'($urandom_range(0, 8000));
            else if (sel < 7) s.fps = 16'(ONE_FRAME_FPS);
            else s.fps = 16'($urandom());
            s.right_x = pick_right();
            s.right_z = pick_right();
            s.pos_x = ($urandom_range(0, 1) == 1) ? COORD_W'($urandom()) : near_coord();
            s.pos_y = ($urandom_range(0, 1) == 1) ? COORD_W'($urandom()) : near_coord();
            s.pos_z = ($urandom_range(0, 1) == 1) ? COORD_W'($urandom()) : near_coord();
            if ($urandom_range(0, 9) < 7) begin
                s.base_size = 10'($urandom());
                s.scale = 16'($urandom());
            end else begin
                s.base_size = 10'($urandom_range(0, 8));
                s.scale = 16'($urandom_range(0, 512));
            end
            pending_sprites.push_back(s);
        end
    endtask

    task automatic wait_drained();
        while (pending_sprites.size() != 0 || in_valid || expected_corners.size() != 0)
            @(posedge clk);
    endtask

    // Sprite driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_quad(in_item);
                sprites_accepted <= sprites_accepted + 1;
            end
            if (!in_valid || !in_stall) begin
                if (pending_sprites.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item <= pending_sprites.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long output hold-off early on, so the block backs up and stalls its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sprites_accepted == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Corner monitor.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_corner(out_item);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("billboard_quad_animator_test: done, errors");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        for (int i = 0; i < NUM_INST; i++) begin
            anim_started[i] = 1'b0;
            frame_pos[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge clk);
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    load_directed();
                end
                1: begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default: begin
                    send_idle_pct = 38;
                    stall_pct = 38;
                end
            endcase
            load_random(phase == 0 ? 95 : 100);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_corners.size() != 0)
            report_failure($sformatf("%0d corners never arrived", expected_corners.size()));
        if (errors == 0) begin
            $display("billboard_quad_animator_test: done, clean");
        end else begin
            $display("billboard_quad_animator_test: done, errors");
        end
        $finish;
    end

endmodule

### files.f
sv/bqa_pkg.sv
sv/bqa_mul.sv
sv/bqa_frame.sv
sv/billboard_quad_animator.sv
sv/bqa_checker.sv
test/billboard_quad_animator_test.sv
